// ----- rtl/ism_pkg.sv -----
// ----------------------------------------------------------------------------
// ism_pkg
// shared widths, codes, command and status types and the exp2 fraction table
// function for the metropolis ising spin update block
// ----------------------------------------------------------------------------
package ism_pkg;

    // lattice size default
    localparam int SIDE_DEFAULT = 64;

    // item and result field widths
    localparam int IDX_W    = 6;
    localparam int IDX_COUNT = 2 ** IDX_W;
    localparam int RAND_W   = 16;
    localparam int DE_W     = 12;
    localparam int MAG_W    = 14;
    localparam int ENERGY_W = 23;

    // configuration widths
    localparam int COUPLING_W = 8;
    localparam int FIELD_W    = 8;
    localparam int BETA_W     = 16;
    localparam int CFG_W      = 16;
    localparam int REG_IDX_W  = 2;

    // neighbour sum, range -4..4
    localparam int NSUM_W = 4;

    // acceptance arithmetic
    localparam int X_W       = DE_W - 1 + BETA_W;
    localparam int Q_FRAC    = 12;
    localparam int FRAC_W    = 8;
    localparam int ROM_DEPTH = 2 ** FRAC_W;
    localparam int ROM_W     = 17;
    localparam int SHIFT_W   = X_W - Q_FRAC;
    localparam int SHAMT_W   = 5;
    localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = SHIFT_W'(17);

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_COUPLING_J = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FIELD_B    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BETA_LOG2E = 2'd2;

    // register reset values
    localparam logic signed [COUPLING_W-1:0] COUPLING_J_RESET = 8'sd1;
    localparam logic signed [FIELD_W-1:0]    FIELD_B_RESET    = 8'sd0;
    localparam logic [BETA_W-1:0]            BETA_LOG2E_RESET = 16'd4096;

    // operation codes
    localparam logic OP_SET     = 1'b0;
    localparam logic OP_ATTEMPT = 1'b1;

    // 2^(-2^b/256) in q30
    localparam logic [63:0] POW_Q30 [FRAC_W] = '{
        64'd1070838486,
        64'd1067942999,
        64'd1062175491,
        64'd1050733751,
        64'd1028218693,
        64'd984625594,
        64'd902905651,
        64'd759250125
    };

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_CTR,
        ST_RD_AM,
        ST_RD_AP,
        ST_RD_BP,
        ST_RD_BM,
        ST_DE,
        ST_EXP,
        ST_DECIDE,
        ST_ENERGY,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        RD_CTR,
        RD_AM,
        RD_AP,
        RD_BP,
        RD_BM
    } rd_sel_t;

    typedef struct packed {
        rd_sel_t rd_sel;
        logic    load;
        logic    cap_s;
        logic    cap_n;
        logic    calc_de;
        logic    calc_x;
        logic    decide;
        logic    calc_e;
        logic    out_load;
        logic    clr_step;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
    } dp_sts_t;

    // 2^(-f/256) in q16, built from q30 partial products
    function automatic logic [ROM_W-1:0] exp2_frac(input logic [FRAC_W-1:0] f);
        logic [63:0] acc;
        acc = 64'd1 << 30;
        for (int b = 0; b < FRAC_W; b++)
        begin
            if (f[b])
            begin
                acc = (acc * POW_Q30[b] + (64'd1 << 29)) >> 30;
            end
        end
        return ROM_W'((acc + (64'd1 << 13)) >> 14);
    endfunction

endpackage

// ----- rtl/ising_metropolis_spin_update.sv -----
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update
// metropolis single spin update on a periodic square ising lattice with
// running magnetization and total energy
// ----------------------------------------------------------------------------
// After reset the lattice memory is swept to all spins up, one site per cycle;
// in_ready stays low for the sweep while configuration writes are taken. Each
// transaction then takes five reads of the center site and its four
// neighbours through the single read port of the lattice memory, then the
// energy change, the exponent multiply, the accept decision with write-back,
// and the energy products, before its result is offered. One item is in work
// at a time; a new item is taken while the previous result still waits in the
// output register.
module ising_metropolis_spin_update #(
    parameter int SIDE = ism_pkg::SIDE_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ism_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [ism_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                operation,
    input  logic [ism_pkg::IDX_W-1:0]           first_index,
    input  logic [ism_pkg::IDX_W-1:0]           second_index,
    input  logic                                spin_value,
    input  logic [ism_pkg::RAND_W-1:0]          random_fraction,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                flipped,
    output logic signed [ism_pkg::DE_W-1:0]     energy_change,
    output logic signed [ism_pkg::MAG_W-1:0]    magnetization,
    output logic signed [ism_pkg::ENERGY_W-1:0] total_energy
);

    import ism_pkg::*;

    dp_cmd_t ctrl_cmd;
    dp_sts_t dp_sts;

    ism_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (dp_sts),
        .cmd       (ctrl_cmd)
    );

    ism_datapath #(
        .SIDE (SIDE)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (ctrl_cmd),
        .sts             (dp_sts),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .operation       (operation),
        .first_index     (first_index),
        .second_index    (second_index),
        .spin_value      (spin_value),
        .random_fraction (random_fraction),
        .flipped         (flipped),
        .energy_change   (energy_change),
        .magnetization   (magnetization),
        .total_energy    (total_energy)
    );

    // one transaction in work at a time
    a_single_item : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in work");

    // result register never overwritten while a result waits
    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.out_load |-> (!out_valid || out_ready))
        else $error("result register loaded over a pending result");

    // no input during the clear sweep
    a_clear_blocks : assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.clr_step |-> !in_ready)
        else $error("input ready during lattice clear");

endmodule

// ----- rtl/ism_ram.sv -----
// ----------------------------------------------------------------------------
// ism_ram
// generic simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module ism_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ism_ctrl.sv -----
// ----------------------------------------------------------------------------
// ism_ctrl
// sequencer for the spin update: lattice clear sweep, neighbour reads,
// energy and acceptance steps, result handoff
// ----------------------------------------------------------------------------
module ism_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  ism_pkg::dp_sts_t sts,
    output ism_pkg::dp_cmd_t cmd
);

    import ism_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_CTR;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RD_CTR;
                end
            end
            ST_RD_CTR:
            begin
                cmd.rd_sel = RD_CTR;
                state_next = ST_RD_AM;
            end
            ST_RD_AM:
            begin
                cmd.rd_sel = RD_AM;
                cmd.cap_s  = 1'b1;
                state_next = ST_RD_AP;
            end
            ST_RD_AP:
            begin
                cmd.rd_sel = RD_AP;
                cmd.cap_n  = 1'b1;
                state_next = ST_RD_BP;
            end
            ST_RD_BP:
            begin
                cmd.rd_sel = RD_BP;
                cmd.cap_n  = 1'b1;
                state_next = ST_RD_BM;
            end
            ST_RD_BM:
            begin
                cmd.rd_sel = RD_BM;
                cmd.cap_n  = 1'b1;
                state_next = ST_DE;
            end
            ST_DE:
            begin
                cmd.cap_n   = 1'b1;
                cmd.calc_de = 1'b1;
                state_next  = ST_EXP;
            end
            ST_EXP:
            begin
                cmd.calc_x = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_ENERGY;
            end
            ST_ENERGY:
            begin
                cmd.calc_e = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/ism_datapath.sv -----
// ----------------------------------------------------------------------------
// ism_datapath
// lattice memory, configuration registers, neighbour sum, energy change,
// exp2 acceptance test, running totals and result registers
// ----------------------------------------------------------------------------
module ism_datapath #(
    parameter int SIDE = ism_pkg::SIDE_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ism_pkg::dp_cmd_t                    cmd,
    output ism_pkg::dp_sts_t                    sts,
    input  logic                                cfg_we,
    input  logic [ism_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [ism_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                operation,
    input  logic [ism_pkg::IDX_W-1:0]           first_index,
    input  logic [ism_pkg::IDX_W-1:0]           second_index,
    input  logic                                spin_value,
    input  logic [ism_pkg::RAND_W-1:0]          random_fraction,
    output logic                                flipped,
    output logic signed [ism_pkg::DE_W-1:0]     energy_change,
    output logic signed [ism_pkg::MAG_W-1:0]    magnetization,
    output logic signed [ism_pkg::ENERGY_W-1:0] total_energy
);

    import ism_pkg::*;

    localparam int CW    = $clog2(SIDE);
    localparam int CELLS = SIDE * SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int SW    = $clog2(CELLS + 1) + 1;
    localparam int PW    = $clog2(4 * CELLS + 1) + 1;
    localparam int MW    = (SW > MAG_W) ? SW : MAG_W;
    localparam int PJW   = PW + COUPLING_W;
    localparam int PBW   = SW + FIELD_W;
    localparam int EW0   = ((PJW > PBW) ? PJW : PBW) + 1;
    localparam int EW    = (EW0 > ENERGY_W) ? EW0 : ENERGY_W;
    localparam logic [CW-1:0] LAST_COORD = CW'(SIDE - 1);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(CELLS - 1);

    // coordinate wrap and exp2 fraction tables
    logic [CW-1:0]    coord_mod [IDX_COUNT];
    logic [ROM_W-1:0] exp_rom [ROM_DEPTH];

    for (genvar gi = 0; gi < IDX_COUNT; gi++)
    begin : g_mod
        assign coord_mod[gi] = CW'(gi % SIDE);
    end

    for (genvar gr = 0; gr < ROM_DEPTH; gr++)
    begin : g_rom
        assign exp_rom[gr] = exp2_frac(FRAC_W'(gr));
    end

    function automatic logic [AW-1:0] site_addr(input logic [CW-1:0] row,
                                                input logic [CW-1:0] col);
        return AW'(row) * AW'(SIDE) + AW'(col);
    endfunction

    // configuration
    logic signed [COUPLING_W-1:0] coupling_j_reg;
    logic signed [FIELD_W-1:0]    field_b_reg;
    logic [BETA_W-1:0]            beta_reg;

    // item
    logic                op_reg;
    logic [CW-1:0]       a_reg;
    logic [CW-1:0]       b_reg;
    logic                want_reg;
    logic [RAND_W-1:0]   rand_reg;

    // work
    logic                     s_reg;
    logic signed [NSUM_W-1:0] n_reg;
    logic signed [DE_W-1:0]   de_reg;
    logic [X_W-1:0]           x_reg;
    logic                     flip_reg;
    logic signed [PJW-1:0]    prod_j_reg;
    logic signed [PBW-1:0]    prod_b_reg;
    logic [AW-1:0]            clr_cnt_reg;

    // totals
    logic signed [SW-1:0] spin_sum_reg;
    logic signed [PW-1:0] pair_sum_reg;

    // results
    logic                      flipped_reg;
    logic signed [DE_W-1:0]    energy_change_reg;
    logic signed [MAG_W-1:0]   magnetization_reg;
    logic signed [ENERGY_W-1:0] total_energy_reg;

    // combinational
    logic [CW-1:0]            am;
    logic [CW-1:0]            ap;
    logic [CW-1:0]            bm;
    logic [CW-1:0]            bp;
    logic [CW-1:0]            rd_row;
    logic [CW-1:0]            rd_col;
    logic [AW-1:0]            center_addr;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic                     ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic                     ram_rdata;
    logic signed [NSUM_W-1:0] nb_step;
    logic signed [NSUM_W-1:0] n_final;
    logic signed [DE_W-1:0]   jn;
    logic signed [DE_W-1:0]   de_half;
    logic signed [DE_W-1:0]   de_calc;
    logic [FRAC_W-1:0]        frac;
    logic [SHAMT_W-1:0]       shamt;
    logic                     shift_big;
    logic [ROM_W-1:0]         prob;
    logic                     de_nonpos;
    logic                     flip;
    logic signed [MW-1:0]     mag_ext;
    logic signed [EW-1:0]     energy_sum;

    // neighbour coordinates with periodic wrap
    assign am = (a_reg == '0) ? LAST_COORD : a_reg - CW'(1);
    assign ap = (a_reg == LAST_COORD) ? '0 : a_reg + CW'(1);
    assign bm = (b_reg == '0) ? LAST_COORD : b_reg - CW'(1);
    assign bp = (b_reg == LAST_COORD) ? '0 : b_reg + CW'(1);

    always_comb
    begin
        rd_row = a_reg;
        rd_col = b_reg;
        case (cmd.rd_sel)
            RD_CTR:
            begin
                rd_row = a_reg;
                rd_col = b_reg;
            end
            RD_AM:
            begin
                rd_row = am;
                rd_col = b_reg;
            end
            RD_AP:
            begin
                rd_row = ap;
                rd_col = b_reg;
            end
            RD_BP:
            begin
                rd_row = a_reg;
                rd_col = bp;
            end
            RD_BM:
            begin
                rd_row = a_reg;
                rd_col = bm;
            end
            default:
            begin
                rd_row = a_reg;
                rd_col = b_reg;
            end
        endcase
    end

    assign ram_raddr   = site_addr(rd_row, rd_col);
    assign center_addr = site_addr(a_reg, b_reg);

    // energy change
    assign nb_step = ram_rdata ? NSUM_W'(1) : -NSUM_W'(1);
    assign n_final = n_reg + nb_step;
    assign jn      = DE_W'(coupling_j_reg) * DE_W'(n_final);
    assign de_half = jn + DE_W'(field_b_reg);
    assign de_calc = (op_reg != OP_ATTEMPT) ? '0
                   : (s_reg ? (de_half + de_half) : -(de_half + de_half));

    // acceptance test
    assign frac      = x_reg[Q_FRAC-1:Q_FRAC-FRAC_W];
    assign shamt     = x_reg[Q_FRAC+SHAMT_W-1:Q_FRAC];
    assign shift_big = (x_reg[X_W-1:Q_FRAC] >= SHIFT_LIMIT);
    assign prob      = shift_big ? '0 : (exp_rom[frac] >> shamt);
    assign de_nonpos = de_reg[DE_W-1] || (de_reg == '0);
    assign flip      = (op_reg == OP_ATTEMPT)
                     ? (de_nonpos || (ROM_W'(rand_reg) <= prob))
                     : (want_reg != s_reg);

    // lattice write: clear sweep or flip
    assign ram_we    = cmd.clr_step || (cmd.decide && flip);
    assign ram_waddr = cmd.clr_step ? clr_cnt_reg : center_addr;
    assign ram_wdata = cmd.clr_step ? 1'b1 : ~s_reg;

    ism_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_lattice (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign sts.clr_last = (clr_cnt_reg == LAST_ADDR);

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coupling_j_reg <= COUPLING_J_RESET;
            field_b_reg    <= FIELD_B_RESET;
            beta_reg       <= BETA_LOG2E_RESET;
            clr_cnt_reg    <= '0;
            spin_sum_reg   <= SW'(CELLS);
            pair_sum_reg   <= PW'(4 * CELLS);
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_COUPLING_J: coupling_j_reg <= cfg_wdata[COUPLING_W-1:0];
                    REG_FIELD_B:    field_b_reg    <= cfg_wdata[FIELD_W-1:0];
                    REG_BETA_LOG2E: beta_reg       <= cfg_wdata[BETA_W-1:0];
                    default:        ;
                endcase
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.decide && flip)
            begin
                spin_sum_reg <= s_reg ? (spin_sum_reg - SW'(2)) : (spin_sum_reg + SW'(2));
                pair_sum_reg <= s_reg ? (pair_sum_reg - (PW'(n_reg) <<< 2))
                                      : (pair_sum_reg + (PW'(n_reg) <<< 2));
            end
        end
    end

    // payload registers
    assign mag_ext    = MW'(spin_sum_reg);
    assign energy_sum = -EW'(prod_j_reg) - EW'(prod_b_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            a_reg    <= coord_mod[first_index];
            b_reg    <= coord_mod[second_index];
            want_reg <= spin_value;
            rand_reg <= random_fraction;
            n_reg    <= '0;
        end
        if (cmd.cap_s)
        begin
            s_reg <= ram_rdata;
        end
        if (cmd.cap_n)
        begin
            n_reg <= n_final;
        end
        if (cmd.calc_de)
        begin
            de_reg <= de_calc;
        end
        if (cmd.calc_x)
        begin
            x_reg <= X_W'(de_reg[DE_W-2:0]) * X_W'(beta_reg);
        end
        if (cmd.decide)
        begin
            flip_reg <= flip;
        end
        if (cmd.calc_e)
        begin
            prod_j_reg <= PJW'(coupling_j_reg) * PJW'(pair_sum_reg);
            prod_b_reg <= PBW'(field_b_reg) * PBW'(spin_sum_reg);
        end
        if (cmd.out_load)
        begin
            flipped_reg       <= flip_reg;
            energy_change_reg <= de_reg;
            magnetization_reg <= mag_ext[MAG_W-1:0];
            total_energy_reg  <= energy_sum[ENERGY_W-1:0];
        end
    end

    assign flipped       = flipped_reg;
    assign energy_change = energy_change_reg;
    assign magnetization = magnetization_reg;
    assign total_energy  = total_energy_reg;

endmodule

// ----- dv/tb_ising_metropolis_spin_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ising_metropolis_spin_update
// self-checking bench for the metropolis spin update block: a queue-fed driver
// offers set and flip-attempt transactions with random gaps, a lattice
// predictor tracks spins, magnetization and bond sum to compute each report,
// and a monitor with random stalls compares every report field by field
// ----------------------------------------------------------------------------
module tb_ising_metropolis_spin_update;

    import ism_pkg::*;

    localparam int LAT = SIDE_DEFAULT;

    localparam logic [63:0] ROOT_Q30 [FRAC_W] = '{
        64'd1070838486,
        64'd1067942999,
        64'd1062175491,
        64'd1050733751,
        64'd1028218693,
        64'd984625594,
        64'd902905651,
        64'd759250125
    };

    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic              up;
        logic [RAND_W-1:0] rnd;
    } spin_cmd_t;

    typedef struct packed {
        logic                flipped;
        logic [DE_W-1:0]     de;
        logic [MAG_W-1:0]    mag;
        logic [ENERGY_W-1:0] energy;
    } spin_report_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [REG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_W-1:0]            cfg_wdata = '0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic                        operation = 1'b0;
    logic [IDX_W-1:0]            first_index = '0;
    logic [IDX_W-1:0]            second_index = '0;
    logic                        spin_value = 1'b0;
    logic [RAND_W-1:0]           random_fraction = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic                        flipped;
    logic signed [DE_W-1:0]      energy_change;
    logic signed [MAG_W-1:0]     magnetization;
    logic signed [ENERGY_W-1:0]  total_energy;

    // predictor state
    bit          spin_up [LAT*LAT];
    int          mag_sum;
    int          bond_sum;
    int          j_coupling;
    int          b_field;
    int unsigned beta_q12;
    int unsigned exp_frac_q16 [ROM_DEPTH];

    spin_cmd_t    pending_cmds [$];
    spin_report_t expected_reports [$];
    spin_report_t oldest_report;

    int gap_left = 0;
    int ready_wait = 0;
    int sink_stall = 0;
    int mismatch_count = 0;
    bit src_no_gap = 1'b0;
    bit sink_no_stall = 1'b0;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;

    ising_metropolis_spin_update u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .first_index     (first_index),
        .second_index    (second_index),
        .spin_value      (spin_value),
        .random_fraction (random_fraction),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .flipped         (flipped),
        .energy_change   (energy_change),
        .magnetization   (magnetization),
        .total_energy    (total_energy)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #6_000_000;
        $display("[ising_metropolis_spin_update] ERROR");
        $finish;
    end

    // 2^(-f/256) in q16 and the reset lattice
    initial
    begin
        logic [63:0] acc;
        for (int f = 0; f < ROM_DEPTH; f++)
        begin
            acc = 64'd1 << 30;
            for (int k = 0; k < FRAC_W; k++)
            begin
                if ((f >> k) & 1)
                begin
                    acc = (acc * ROOT_Q30[k] + (64'd1 << 29)) >> 30;
                end
            end
            exp_frac_q16[f] = int'((acc + (64'd1 << 13)) >> 14);
        end
        foreach (spin_up[i])
        begin
            spin_up[i] = 1'b1;
        end
        mag_sum    = LAT * LAT;
        bond_sum   = 4 * LAT * LAT;
        j_coupling = COUPLING_J_RESET;
        b_field    = FIELD_B_RESET;
        beta_q12   = BETA_LOG2E_RESET;
    end

    function automatic int site_spin(input int a, input int b);
        return spin_up[a * LAT + b] ? 1 : -1;
    endfunction

    function automatic spin_report_t step_lattice(input spin_cmd_t c);
        int           a;
        int           b;
        int           s;
        int           n;
        int           de;
        bit           flip;
        int unsigned  x;
        int unsigned  shift_amt;
        int unsigned  p;
        longint       energy;
        spin_report_t rep;
        a = int'(c.row) % LAT;
        b = int'(c.col) % LAT;
        s = site_spin(a, b);
        n = site_spin((a + LAT - 1) % LAT, b) + site_spin((a + 1) % LAT, b)
          + site_spin(a, (b + 1) % LAT) + site_spin(a, (b + LAT - 1) % LAT);
        de = 0;
        if (c.op == OP_SET)
        begin
            flip = ((c.up ? 1 : -1) != s);
        end
        else
        begin
            de = 2 * s * (j_coupling * n + b_field);
            if (de <= 0)
            begin
                flip = 1'b1;
            end
            else
            begin
                x = de * beta_q12;
                shift_amt = x >> Q_FRAC;
                p = (shift_amt >= 17) ? 0 : (exp_frac_q16[(x >> 4) & 255] >> shift_amt);
                flip = (c.rnd <= p);
            end
        end
        if (flip)
        begin
            spin_up[a * LAT + b] = (s < 0);
            mag_sum  -= 2 * s;
            bond_sum -= 4 * s * n;
        end
        energy = -longint'(j_coupling) * bond_sum - longint'(b_field) * mag_sum;
        rep.flipped = flip;
        rep.de      = DE_W'(de);
        rep.mag     = MAG_W'(mag_sum);
        rep.energy  = ENERGY_W'(energy);
        return rep;
    endfunction

    function automatic spin_cmd_t random_cmd();
        spin_cmd_t   c;
        int unsigned pick;
        c.op = ($urandom_range(0, 99) < 65) ? OP_ATTEMPT : OP_SET;
        // most traffic in a small window across the wrap so spins interact
        if ($urandom_range(0, 99) < 60)
        begin
            c.row = IDX_W'(60 + $urandom_range(0, 7));
            c.col = IDX_W'(60 + $urandom_range(0, 7));
        end
        else
        begin
            c.row = IDX_W'($urandom);
            c.col = IDX_W'($urandom);
        end
        c.up = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 9);
        if (pick < 5)
        begin
            c.rnd = RAND_W'($urandom);
        end
        else if (pick < 8)
        begin
            c.rnd = RAND_W'($urandom_range(0, 600));
        end
        else if (pick == 8)
        begin
            c.rnd = '0;
        end
        else
        begin
            c.rnd = '1;
        end
        return c;
    endfunction

    task automatic push_cmd(input logic op, input int row, input int col, input logic up,
                            input logic [RAND_W-1:0] rnd);
        pending_cmds.push_back('{op, IDX_W'(row), IDX_W'(col), up, rnd});
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_regs(input logic [7:0] j, input logic [7:0] bf, input logic [15:0] beta);
        write_reg(REG_COUPLING_J, {8'($urandom), j});
        write_reg(REG_FIELD_B, {8'($urandom), bf});
        write_reg(REG_BETA_LOG2E, beta);
        j_coupling = int'($signed(j));
        b_field    = int'($signed(bf));
        beta_q12   = beta;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || in_valid || expected_reports.size() != 0);
        repeat (16) @(negedge clk);
    endtask

    task automatic random_burst(input int count, input bit quiet_src, input bit quiet_snk,
                                input bit with_hold);
        @(negedge clk);
        src_no_gap    = quiet_src;
        sink_no_stall = quiet_snk;
        repeat (count) pending_cmds.push_back(random_cmd());
        if (with_hold)
        begin
            hold_go = 1'b1;
        end
        wait_drained();
    endtask

    task automatic field_check(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_reports.push_back(step_lattice({operation, first_index, second_index,
                                                         spin_value, random_fraction}));
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_cmds.size() != 0)
                begin
                    {operation, first_index, second_index, spin_value, random_fraction}
                        <= pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    gap_left <= src_no_gap ? 0 : $urandom_range(0, 5);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and result-side flow control
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            ready_wait <= 0;
            hold_done  <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result with no transaction pending", $time);
                end
                else
                begin
                    oldest_report = expected_reports.pop_front();
                    field_check("flipped", oldest_report.flipped, flipped);
                    field_check("energy_change", $signed(oldest_report.de), energy_change);
                    field_check("magnetization", $signed(oldest_report.mag), magnetization);
                    field_check("total_energy", $signed(oldest_report.energy), total_energy);
                end
            end
            if (ready_wait != 0)
            begin
                ready_wait <= ready_wait - 1;
                out_ready  <= (ready_wait == 1);
            end
            else if (hold_go && !hold_done)
            begin
                // long hold-off so the block backs up into its input
                hold_done  <= 1'b1;
                ready_wait <= 400;
                out_ready  <= 1'b0;
            end
            else if (out_valid && out_ready)
            begin
                sink_stall = sink_no_stall ? 0 : $urandom_range(0, 5);
                ready_wait <= sink_stall;
                out_ready  <= (sink_stall == 0);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        @(negedge clk);

        // default settings, lattice all up
        set_regs(8'h01, 8'h00, 16'd4096);
        push_cmd(OP_ATTEMPT, 0, 0, 1'b0, 16'hffff);
        push_cmd(OP_ATTEMPT, 0, 0, 1'b1, 16'd256);
        push_cmd(OP_ATTEMPT, 0, 0, 1'b0, 16'd0);
        push_cmd(OP_SET, 63, 63, 1'b0, 16'h5a5a);
        push_cmd(OP_SET, 63, 63, 1'b0, 16'ha5a5);
        push_cmd(OP_SET, 0, 63, 1'b1, 16'd0);
        push_cmd(OP_ATTEMPT, 0, 63, 1'b1, 16'd4097);
        push_cmd(OP_ATTEMPT, 63, 0, 1'b0, 16'd4096);
        push_cmd(OP_ATTEMPT, 63, 63, 1'b1, 16'hffff);
        push_cmd(OP_SET, 32, 32, 1'b0, 16'd1);
        push_cmd(OP_SET, 32, 33, 1'b0, 16'd2);
        push_cmd(OP_SET, 32, 32, 1'b1, 16'd3);
        push_cmd(OP_ATTEMPT, 32, 33, 1'b0, 16'h8000);
        random_burst(240, 1'b0, 1'b0, 1'b0);

        // zero inverse temperature accepts everything
        set_regs(8'h7f, 8'h80, 16'd0);
        push_cmd(OP_ATTEMPT, 5, 5, 1'b0, 16'hffff);
        push_cmd(OP_ATTEMPT, 5, 5, 1'b1, 16'hffff);
        random_burst(220, 1'b1, 1'b1, 1'b0);

        set_regs(8'h80, 8'h7f, 16'hffff);
        push_cmd(OP_ATTEMPT, 61, 2, 1'b0, 16'd0);
        push_cmd(OP_ATTEMPT, 17, 40, 1'b1, 16'd1);
        random_burst(220, 1'b0, 1'b0, 1'b0);

        set_regs(8'h01, 8'h00, 16'd8192);
        random_burst(240, 1'b0, 1'b0, 1'b1);

        set_regs(8'h01, 8'h01, 16'd2048);
        random_burst(240, 1'b0, 1'b1, 1'b0);

        set_regs(8'hff, 8'h00, 16'd3000);
        random_burst(240, 1'b1, 1'b0, 1'b0);

        set_regs(8'($urandom), 8'($urandom), 16'($urandom));
        random_burst(240, 1'b0, 1'b0, 1'b0);

        set_regs(8'($urandom), 8'($urandom), 16'($urandom_range(0, 12000)));
        random_burst(240, 1'b0, 1'b0, 1'b0);

        repeat (20) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("[ising_metropolis_spin_update] OK");
        end
        else
        begin
            $display("[ising_metropolis_spin_update] ERROR");
        end
        $finish;
    end

endmodule

// ----- ising_metropolis_spin_update.f -----
rtl/ism_pkg.sv
rtl/ism_ram.sv
rtl/ism_ctrl.sv
rtl/ism_datapath.sv
rtl/ising_metropolis_spin_update.sv
dv/tb_ising_metropolis_spin_update.sv
